### rtl/core/ivs_pkg.sv
// Package for the greedy interval scheduler: sizes, field widths, codes,
// state types and the control structs shared by the sequencer and the top level.
// No dependencies.
package ivs_pkg;

  // Capacity and field sizes.
  localparam int unsigned MAX_INTERVALS = 1024;
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned ADDR_W        = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned POS_W         = 10;
  localparam int unsigned IV_W          = 2 * COORD_W;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_FIELDS_W   = 2 * COORD_W + POS_W;
  localparam int unsigned IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W  = 2 * CNT_W + 2;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Item kind carried on tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Top-level control states.
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SEL,
    TOP_RESULT
  } top_state_e;

  // Selection sequencer states.
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_COMMIT
  } sel_state_e;

  // Start request from the top level to the sequencer.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } sel_ctrl_t;

  // Status from the sequencer back to the top level.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } sel_stat_t;

endpackage

### rtl/core/ivs_ram.sv
// Generic simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module ivs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the output holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ivs_sel.sv
// Selection sequencer: repeated passes over the interval memory, each pass
// finding the next interval in (end, arrival) order that fits, and writing
// its number to the chosen-list memory. Depends on ivs_pkg.
module ivs_sel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ivs_pkg::sel_ctrl_t        ctrl_i,
  output ivs_pkg::sel_stat_t        stat_o,
  output logic                      iv_re_o,
  output logic [ivs_pkg::ADDR_W-1:0] iv_raddr_o,
  input  logic [ivs_pkg::IV_W-1:0]  iv_rdata_i,
  output logic                      ch_we_o,
  output logic [ivs_pkg::ADDR_W-1:0] ch_waddr_o,
  output logic [ivs_pkg::ADDR_W-1:0] ch_wdata_o
);
  import ivs_pkg::*;

  sel_state_e         state_q, state_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               v_q, v_d;
  logic [ADDR_W-1:0]  ev_idx_q, ev_idx_d;
  logic               found_q, found_d;
  logic [COORD_W-1:0] best_end_q, best_end_d;
  logic [ADDR_W-1:0]  best_idx_q, best_idx_d;
  logic               have_last_q, have_last_d;
  logic [COORD_W-1:0] last_end_q, last_end_d;
  logic [ADDR_W-1:0]  last_idx_q, last_idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               issue;
  logic [COORD_W-1:0] ev_begin;
  logic [COORD_W-1:0] ev_end;
  logic               after_last;
  logic               better;

  // Fields of the interval word read in the previous cycle.
  assign ev_begin = iv_rdata_i[COORD_W-1:0];
  assign ev_end   = iv_rdata_i[IV_W-1:COORD_W];

  // A candidate must sort after the last chosen interval and begin no
  // earlier than its end; in the first pass every interval is a candidate.
  assign after_last = !have_last_q ||
                      ((ev_begin >= last_end_q) &&
                       ((ev_end > last_end_q) ||
                        ((ev_end == last_end_q) && (ev_idx_q > last_idx_q))));

  // Entries arrive in increasing order, so a tie keeps the earlier one.
  assign better = !found_q || (ev_end < best_end_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEL_IDLE: begin
        if (ctrl_i.start) begin
          state_d = SEL_SCAN;
        end
      end
      SEL_SCAN: begin
        if ((iss_q == n_q) && !v_q) begin
          state_d = SEL_COMMIT;
        end
      end
      SEL_COMMIT: begin
        state_d = found_q ? SEL_SCAN : SEL_IDLE;
      end
      default: begin
        state_d = SEL_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    issue        = 1'b0;
    ch_we_o      = 1'b0;
    stat_o.done  = 1'b0;
    stat_o.count = cnt_q;
    unique case (state_q)
      SEL_IDLE: begin
      end
      SEL_SCAN: begin
        issue = (iss_q < n_q);
      end
      SEL_COMMIT: begin
        ch_we_o     = found_q;
        stat_o.done = !found_q;
      end
      default: begin
      end
    endcase
  end

  assign iv_re_o      = issue;
  assign iv_raddr_o   = iss_q[ADDR_W-1:0];
  assign ch_waddr_o   = cnt_q[ADDR_W-1:0];
  assign ch_wdata_o   = best_idx_q;

  // Datapath updates.
  always_comb begin
    n_d         = n_q;
    iss_d       = iss_q;
    v_d         = 1'b0;
    ev_idx_d    = ev_idx_q;
    found_d     = found_q;
    best_end_d  = best_end_q;
    best_idx_d  = best_idx_q;
    have_last_d = have_last_q;
    last_end_d  = last_end_q;
    last_idx_d  = last_idx_q;
    cnt_d       = cnt_q;
    if ((state_q == SEL_IDLE) && ctrl_i.start) begin
      n_d         = ctrl_i.n;
      iss_d       = '0;
      found_d     = 1'b0;
      have_last_d = 1'b0;
      cnt_d       = '0;
    end
    if (state_q == SEL_SCAN) begin
      v_d      = issue;
      ev_idx_d = iss_q[ADDR_W-1:0];
      if (issue) begin
        iss_d = iss_q + CNT_W'(1);
      end
      if (v_q && after_last && better) begin
        found_d    = 1'b1;
        best_end_d = ev_end;
        best_idx_d = ev_idx_q;
      end
    end
    if ((state_q == SEL_COMMIT) && found_q) begin
      cnt_d       = cnt_q + CNT_W'(1);
      last_end_d  = best_end_q;
      last_idx_d  = best_idx_q;
      have_last_d = 1'b1;
      found_d     = 1'b0;
      iss_d       = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEL_IDLE;
      n_q         <= '0;
      iss_q       <= '0;
      v_q         <= 1'b0;
      found_q     <= 1'b0;
      have_last_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      iss_q       <= iss_d;
      v_q         <= v_d;
      found_q     <= found_d;
      have_last_q <= have_last_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    best_end_q <= best_end_d;
    best_idx_q <= best_idx_d;
    last_end_q <= last_end_d;
    last_idx_q <= last_idx_d;
  end

endmodule

### rtl/core/interval_schedule_greedy.sv
// Greedy interval scheduler (earliest end first). A read's result passes through the pending
// stage and then the output register, one read per cycle when the sink keeps up.
// A final load of n stored intervals choosing c of them holds the input off while
// its selection runs c+1 passes, each reading all n; then its result is given.
// Reset (asynchronous, active low) empties the load count, chosen count and flag;
// the memories are not cleared. Depends on ivs_pkg, ivs_ram and ivs_sel.
module interval_schedule_greedy (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // begin_pos [23:0], end_pos [47:24], position [57:48], zero padding above
  input  logic [ivs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // kind
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // selected_count [10:0], selected_id [21:11], overflow [22], out_of_range [23]
  output logic [ivs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ivs_pkg::*;

  top_state_e        state_q, state_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic              ovf_q, ovf_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  pend_cnt_q, pend_cnt_d;
  logic              pend_ovf_q, pend_ovf_d;
  logic              pend_oor_q, pend_oor_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic [COORD_W-1:0] in_begin;
  logic [COORD_W-1:0] in_end;
  logic [POS_W-1:0]   in_pos;
  logic               accept;
  logic               out_free;
  logic               is_load;
  logic               is_read;
  logic               room;
  logic [CNT_W-1:0]   n_next;
  logic [CNT_W-1:0]   rd_id;

  sel_ctrl_t          sel_ctrl;
  sel_stat_t          sel_stat;
  logic               iv_re;
  logic [ADDR_W-1:0]  iv_raddr;
  logic [IV_W-1:0]    iv_rdata;
  logic               ch_we;
  logic [ADDR_W-1:0]  ch_waddr;
  logic [ADDR_W-1:0]  ch_wdata;
  logic [ADDR_W-1:0]  ch_rdata;

  // Unpack the input transaction.
  assign in_begin = s_axis_tdata[COORD_W-1:0];
  assign in_end   = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_pos   = s_axis_tdata[IN_FIELDS_W-1:2*COORD_W];

  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_load  = accept && (s_axis_tuser == KIND_LOAD);
  assign is_read  = accept && (s_axis_tuser == KIND_READ);
  assign room     = (loaded_q < CNT_W'(MAX_INTERVALS));
  assign n_next   = room ? (loaded_q + CNT_W'(1)) : loaded_q;
  assign rd_id    = CNT_W'(ch_rdata) + CNT_W'(1);

  // Interval memory: {end, begin} per arrival slot.
  ivs_ram #(
    .DEPTH (MAX_INTERVALS),
    .WIDTH (IV_W)
  ) u_iv_ram (
    .clk_i   (clk_i),
    .we_i    (is_load && room),
    .waddr_i (loaded_q[ADDR_W-1:0]),
    .wdata_i ({in_end, in_begin}),
    .re_i    (iv_re),
    .raddr_i (iv_raddr),
    .rdata_o (iv_rdata)
  );

  // Chosen-list memory: written only during selection, read only while idle.
  ivs_ram #(
    .DEPTH (MAX_INTERVALS),
    .WIDTH (ADDR_W)
  ) u_ch_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (is_read),
    .raddr_i (in_pos[ADDR_W-1:0]),
    .rdata_o (ch_rdata)
  );

  assign sel_ctrl.start = is_load && s_axis_tlast;
  assign sel_ctrl.n     = n_next;

  ivs_sel u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .stat_o     (sel_stat),
    .iv_re_o    (iv_re),
    .iv_raddr_o (iv_raddr),
    .iv_rdata_i (iv_rdata),
    .ch_we_o    (ch_we),
    .ch_waddr_o (ch_waddr),
    .ch_wdata_o (ch_wdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TOP_IDLE: begin
        if (sel_ctrl.start) begin
          state_d = TOP_SEL;
        end
      end
      TOP_SEL: begin
        if (sel_stat.done) begin
          state_d = TOP_RESULT;
        end
      end
      TOP_RESULT: begin
        if (out_free && !pend_q) begin
          state_d = TOP_IDLE;
        end
      end
      default: begin
        state_d = TOP_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      TOP_IDLE: begin
        s_axis_tready = !pend_q || out_free;
      end
      TOP_SEL, TOP_RESULT: begin
        s_axis_tready = 1'b0;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Load bookkeeping, pending read and output register.
  always_comb begin
    loaded_d   = loaded_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    pend_ovf_d = pend_ovf_q;
    pend_oor_d = pend_oor_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    // The output slot empties when its transaction completes.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // A read whose memory data is ready moves into the output slot.
    if (pend_q && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_TDATA_W'({pend_oor_q, pend_ovf_q,
                                (pend_oor_q ? CNT_W'(0) : rd_id), pend_cnt_q});
      pend_d    = 1'b0;
    end

    // Final-load result once the selection is complete.
    if ((state_q == TOP_RESULT) && out_free && !pend_q) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_TDATA_W'({1'b0, ovf_q, CNT_W'(0), sel_stat.count});
    end

    // Store a load; the first load of a batch clears the flag.
    if (is_load) begin
      ovf_d = (loaded_q == '0) ? 1'b0 : ovf_q;
      if (room) begin
        loaded_d = loaded_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (s_axis_tlast) begin
        loaded_d = '0;
      end
    end

    // Issue a read and capture the state that belongs with it.
    if (is_read) begin
      pend_d     = 1'b1;
      pend_cnt_d = sel_stat.count;
      pend_ovf_d = ovf_q;
      pend_oor_d = !(CNT_W'(in_pos) < sel_stat.count);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TOP_IDLE;
      loaded_q  <= '0;
      ovf_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      loaded_q  <= loaded_d;
      ovf_q     <= ovf_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_cnt_q <= pend_cnt_d;
    pend_ovf_q <= pend_ovf_d;
    pend_oor_q <= pend_oor_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### bench/tb_interval_schedule_greedy.sv
`timescale 1ns / 100ps
// Testbench for the greedy interval scheduler: streams load and read transactions,
// predicts every result and checks the output stream field by field.
// Depends on ivs_pkg and the interval_schedule_greedy RTL.
module tb_interval_schedule_greedy;
  import ivs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 1044;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned REPORT_MAX   = 10;

  // One input item as the sender sees it.
  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] iv_begin;
    logic [COORD_W-1:0] iv_end;
    logic               last;
    logic [POS_W-1:0]   pos;
  } sched_item_t;

  // One result item as it appears on the output stream.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] id;
    logic             overflow;
    logic             out_of_range;
  } sched_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    s_axis_tuser  = KIND_LOAD;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  // Predicted scheduler state.
  logic [COORD_W-1:0] begin_mem  [MAX_INTERVALS];
  logic [COORD_W-1:0] end_mem    [MAX_INTERVALS];
  logic [ADDR_W-1:0]  chosen_mem [MAX_INTERVALS];
  int unsigned        loaded_n     = 0;
  int unsigned        chosen_n     = 0;
  logic               dropped_flag = 1'b0;

  sched_item_t   item_q[$];
  sched_result_t result_q[$];
  sched_item_t   offered;

  int unsigned accepted_n = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  logic        in_burst   = 1'b0;
  logic        out_burst  = 1'b0;
  int unsigned err_cnt    = 0;

  interval_schedule_greedy uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  // Applies one accepted item to the predicted state and queues its result, if any.
  function automatic void predict_schedule(sched_item_t it);
    int unsigned        order [MAX_INTERVALS];
    int unsigned        i;
    int unsigned        j;
    int unsigned        k;
    logic [COORD_W-1:0] last_stop;
    sched_result_t      r;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      if (loaded_n == 0) dropped_flag = 1'b0;
      if (loaded_n < MAX_INTERVALS) begin
        begin_mem[ADDR_W'(loaded_n)] = it.iv_begin;
        end_mem[ADDR_W'(loaded_n)]   = it.iv_end;
        loaded_n++;
      end else begin
        dropped_flag = 1'b1;
      end
      if (!it.last) return;
      // Stable insertion sort by end, so equal ends keep arrival order.
      for (i = 0; i < loaded_n; i++) begin
        j = i;
        while (j > 0 && end_mem[ADDR_W'(order[ADDR_W'(j-1)])] > end_mem[ADDR_W'(i)]) begin
          order[ADDR_W'(j)] = order[ADDR_W'(j-1)];
          j--;
        end
        order[ADDR_W'(j)] = i;
      end
      // Greedy pass: take each interval that starts at or after the last chosen end.
      chosen_n = 0;
      if (loaded_n != 0) begin
        chosen_mem[0] = order[0][ADDR_W-1:0];
        chosen_n      = 1;
        last_stop     = end_mem[ADDR_W'(order[0])];
        for (i = 1; i < loaded_n; i++) begin
          k = order[ADDR_W'(i)];
          if (last_stop <= begin_mem[ADDR_W'(k)]) begin
            chosen_mem[ADDR_W'(chosen_n)] = k[ADDR_W-1:0];
            chosen_n++;
            last_stop = end_mem[ADDR_W'(k)];
          end
        end
      end
      loaded_n   = 0;
      r.count    = chosen_n[CNT_W-1:0];
      r.overflow = dropped_flag;
    end else begin
      r.count    = chosen_n[CNT_W-1:0];
      r.overflow = dropped_flag;
      if (it.pos < chosen_n) begin
        r.id = CNT_W'(chosen_mem[it.pos]) + CNT_W'(1);
      end else begin
        r.out_of_range = 1'b1;
      end
    end
    result_q.insert(result_q.size(), r);
  endfunction

  task automatic queue_load(input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] e,
                            input logic last);
    sched_item_t it;
    it.kind     = KIND_LOAD;
    it.iv_begin = b;
    it.iv_end   = e;
    it.last     = last;
    it.pos      = POS_W'($urandom_range(0, 1023));
    item_q.insert(item_q.size(), it);
  endtask

  // Reads carry random content in the fields that they do not use.
  task automatic queue_read(input int unsigned pos);
    sched_item_t it;
    it.kind     = KIND_READ;
    it.iv_begin = COORD_W'($urandom_range(0, 24'hFFFFFF));
    it.iv_end   = COORD_W'($urandom_range(0, 24'hFFFFFF));
    it.last     = 1'($urandom_range(0, 1));
    it.pos      = pos[POS_W-1:0];
    item_q.insert(item_q.size(), it);
  endtask

  // Sender: offers queued items with random gaps and predicts each transaction.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    sched_item_t           nxt;
    int unsigned           gap_nxt;
    logic [IN_TDATA_W-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      gap_nxt = gap_left;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_schedule(offered);
        accepted_n <= accepted_n + 1;
        if ($urandom_range(0, 63) == 0) in_burst <= !in_burst;
        gap_nxt = in_burst ? 0 : $urandom_range(0, 15);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_nxt != 0) begin
          gap_nxt--;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          nxt  = item_q.pop_front();
          word = '0;
          word[COORD_W-1:0]                     = nxt.iv_begin;
          word[2*COORD_W-1:COORD_W]             = nxt.iv_end;
          word[2*COORD_W+POS_W-1:2*COORD_W]     = nxt.pos;
          s_axis_tdata  <= word;
          s_axis_tuser  <= nxt.kind;
          s_axis_tlast  <= nxt.last;
          offered       <= nxt;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      gap_left <= gap_nxt;
    end
  end

  // Long receiver hold-off, once, while reads keep coming, so the input backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_n >= HOLD_AFTER && s_axis_tvalid &&
                 s_axis_tready && s_axis_tuser == KIND_READ) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random stalls, and every transaction checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    sched_result_t got;
    sched_result_t want;
    int unsigned   stall_nxt;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      stall_nxt = (stall_left != 0) ? stall_left - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got.count        = m_axis_tdata[CNT_W-1:0];
        got.id           = m_axis_tdata[2*CNT_W-1:CNT_W];
        got.overflow     = m_axis_tdata[2*CNT_W];
        got.out_of_range = m_axis_tdata[2*CNT_W+1];
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: result with none expected: count=%0d id=%0d ovf=%0b oor=%0b",
                     $time, got.count, got.id, got.overflow, got.out_of_range);
        end else begin
          want = result_q.pop_front();
          if (got.count !== want.count || got.id !== want.id ||
              got.overflow !== want.overflow ||
              got.out_of_range !== want.out_of_range) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display("%0t: mismatch: expected count=%0d id=%0d ovf=%0b oor=%0b,",
                       $time, want.count, want.id, want.overflow, want.out_of_range,
                       " got count=%0d id=%0d ovf=%0b oor=%0b",
                       got.count, got.id, got.overflow, got.out_of_range);
          end
        end
        if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
        stall_nxt = out_burst ? 0 : $urandom_range(0, 15);
      end
      stall_left    <= stall_nxt;
      m_axis_tready <= (stall_nxt == 0) && (hold_left == 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned        k;
    int unsigned        n;
    int unsigned        slot;
    int unsigned        reads;
    int unsigned        mode;
    int unsigned        stop_at;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] e;

    // Reads before any selection, then a single interval at the top of the range.
    queue_read(0);
    queue_read(1023);
    queue_load(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    queue_read(0);
    queue_read(1);
    // Equal ends must be taken in arrival order; a begin equal to the last end counts.
    queue_load(24'd0, 24'd5, 1'b0);
    queue_load(24'd0, 24'd5, 1'b0);
    queue_load(24'd5, 24'd10, 1'b0);
    queue_load(24'd3, 24'd10, 1'b0);
    queue_load(24'd10, 24'd10, 1'b1);
    for (k = 0; k < 4; k++) queue_read(k);
    // An interval whose begin lies past its end.
    queue_load(24'hFFFFFF, 24'd0, 1'b0);
    queue_load(24'd0, 24'hFFFFFF, 1'b1);
    queue_read(1);
    queue_read(2);

    // Full store: two loads past capacity are dropped, the second one closes the batch.
    // The intervals fall into 32 disjoint slots, so 32 are chosen.
    for (k = 0; k < MAX_INTERVALS + 2; k++) begin
      slot = k % 32;
      b = COORD_W'(slot * 1000 + $urandom_range(0, 10));
      e = COORD_W'(slot * 1000 + 500 + $urandom_range(0, 400));
      queue_load(b, e, k == MAX_INTERVALS + 1);
    end
    for (k = 0; k < 34; k++) queue_read(k);

    // Random batches with reads, mixed with stray reads and unfinished batches.
    stop_at = item_q.size() + RANDOM_ITEMS;
    while (item_q.size() < stop_at) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 99) < 85) begin
        mode = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          unique case (mode)
            0: begin
              b = COORD_W'($urandom_range(0, 300));
              e = b + COORD_W'($urandom_range(0, 60));
            end
            1: begin
              b = COORD_W'($urandom_range(0, 4) * 10);
              e = COORD_W'($urandom_range(1, 5) * 10);
            end
            2: begin
              b = COORD_W'($urandom_range(0, 24'hFFFFFF));
              e = COORD_W'($urandom_range(0, 24'hFFFFFF));
            end
            default: begin
              b = 24'hFFFFFF - COORD_W'($urandom_range(0, 300));
              e = 24'hFFFFFF - COORD_W'($urandom_range(0, 300));
            end
          endcase
          queue_load(b, e, k == n - 1);
          if ($urandom_range(0, 9) == 0) queue_read($urandom_range(0, n));
        end
        reads = $urandom_range(0, n + 2);
        for (k = 0; k < reads; k++)
          queue_read(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, n));
      end else begin
        // Loads left open join the next batch.
        for (k = 0; k < n % 4; k++)
          queue_load(COORD_W'($urandom_range(0, 400)), COORD_W'($urandom_range(0, 400)),
                     1'b0);
        for (k = 0; k < n; k++) queue_read($urandom_range(0, 1023));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (item_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("interval_schedule_greedy test passed");
    end else begin
      $display("interval_schedule_greedy test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("interval_schedule_greedy test failed");
    $finish;
  end

endmodule
